@@ rtl/art_pkg.sv @@
// shared constants and types for the address region table
// no dependencies
`timescale 1ns / 1ps
package art_pkg;
    localparam int MaxRegions = 16;
    localparam int PageShift  = 12;
    localparam int AddrBits   = 39;
    localparam int IdxW       = $clog2(MaxRegions);
    localparam int CntW       = $clog2(MaxRegions + 1);
    localparam int SpW        = AddrBits - PageShift;
    localparam int EpW        = SpW + 1;

    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic CFG_WIN_LOW  = 1'b0;
    localparam logic CFG_WIN_HIGH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_CHK, S_OUT
    } t_state;
endpackage

@@ rtl/address_region_table_unit.sv @@
// top level of the address region table: region store, sequencer, one comparator
// depends on art_pkg
// channel | dir | handshake     | payload
// in      | in  | valid / stall | operation, address, length, region_permissions, write_access
// out     | out | valid / stall | status, hit, region_index, found_*, allowed, regions_in_use
// cfg     | in  | valid / ready | index, data
// lookup scans all n held regions one slot a cycle; map does too, but stops once the request is bad
// a map that inserts then moves each later slot up one place and writes the new region; a clear skips the scan
// check: finds the region that holds the start, checks its permissions, moves on to its end; a failed check ends early
// reset is synchronous; the table empties at once, no clearing pass
// the result register holds while out stall is high; input is taken only when idle,
// at the earliest in the cycle after the result beat
`timescale 1ns / 1ps
module address_region_table_unit
    import art_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  logic [AddrBits-1:0] i_address,
    input  logic [AddrBits:0]   i_length,
    input  logic [2:0]          i_region_permissions,
    input  logic                i_write_access,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic                o_hit,
    output logic [3:0]          o_region_index,
    output logic [38:0]         o_found_start,
    output logic [39:0]         o_found_end,
    output logic [2:0]          o_found_permissions,
    output logic                o_allowed,
    output logic [4:0]          o_regions_in_use,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    logic [SpW-1:0] r_sp [MaxRegions];
    logic [EpW-1:0] r_ep [MaxRegions];
    logic [2:0]     r_fl [MaxRegions];
    logic [CntW-1:0] r_cnt;
    logic [AddrBits-1:0] r_wlo;
    logic [AddrBits:0]   r_whi;
    t_state r_st, n_st;
    logic [1:0] r_op;
    logic [AddrBits:0] r_s, r_e;
    logic [2:0] r_perm;
    logic r_wr, r_bad, r_found;
    logic [CntW-1:0] r_i, r_pos;
    logic [IdxW-1:0] r_k;

    // one comparator slot: region at r_i
    logic [IdxW-1:0] ix;
    logic [AddrBits:0] cs, ce;
    assign ix = r_i[IdxW-1:0];
    assign cs = {1'b0, r_sp[ix], {PageShift{1'b0}}};
    assign ce = {r_ep[ix], {PageShift{1'b0}}};
    logic in_tab;
    assign in_tab = r_i < r_cnt;
    logic contains;
    assign contains = (cs <= r_s) && (ce > r_s);

    logic [AddrBits:0] pm, ms, me, cend;
    logic [AddrBits+1:0] msum;
    assign pm   = (AddrBits+1)'((1 << PageShift) - 1);
    assign msum = {2'b0, i_address} + {1'b0, i_length} + {1'b0, pm};
    assign ms   = {1'b0, i_address} & ~pm;
    assign me   = msum[AddrBits:0] & ~pm;
    assign cend = {1'b0, i_address} + i_length;
    logic mbad, cbad;
    assign mbad = !(ms < me) || ms < {1'b0, r_wlo} || me > r_whi || msum[AddrBits+1]
                  || me > {1'b1, {AddrBits{1'b0}}};
    assign cbad = !({1'b0, i_address} < cend) || i_address < r_wlo || cend > r_whi;

    logic chk_fail;
    assign chk_fail = (r_fl[r_k] & (r_wr ? 3'd2 : 3'd1)) == 3'd0 ||
                      (r_wr && r_fl[r_k][2] &&
                       r_s < {1'b0, r_sp[r_k], {PageShift{1'b0}}}
                             + (AddrBits+1)'(1 << PageShift));

    logic acc;
    assign acc = i_valid && (r_st == S_IDLE);
    assign o_stall = r_st != S_IDLE;
    assign o_cfg_ready = r_st == S_IDLE;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (acc) n_st = (i_operation == OP_CLEAR) ? S_OUT : S_SCAN;
            S_SCAN: begin
                if (!in_tab) begin
                    if (r_op == OP_MAP && !r_bad && r_cnt < CntW'(MaxRegions))
                        n_st = S_SHIFT;
                    else if (r_op == OP_CHECK && !r_bad && r_s < r_e && r_found)
                        n_st = S_CHK;
                    else
                        n_st = S_OUT;
                end
            end
            S_SHIFT: if (r_i == r_pos) n_st = S_OUT;
            S_CHK:   n_st = chk_fail ? S_OUT : S_SCAN;
            S_OUT:   if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= n_st == S_OUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wlo <= 39'd2097152;
            r_whi <= 40'd2952790016;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WIN_LOW) r_wlo <= i_cfg_data[AddrBits-1:0];
                else                            r_whi <= i_cfg_data[AddrBits:0];
            end
            case (r_st)
                S_IDLE: if (acc) begin
                    r_op <= i_operation;
                    r_perm <= i_region_permissions;
                    r_wr <= i_write_access;
                    r_i <= '0;
                    r_pos <= '0;
                    r_found <= 1'b0;
                    r_k <= '0;
                    if (i_operation == OP_MAP) begin
                        r_s <= ms; r_e <= me; r_bad <= mbad;
                    end else begin
                        r_s <= {1'b0, i_address}; r_e <= cend;
                        r_bad <= (i_operation == OP_CHECK) && cbad;
                    end
                    o_status <= ST_OK; o_hit <= 1'b0; o_region_index <= '0;
                    o_found_start <= '0; o_found_end <= '0; o_found_permissions <= '0;
                    o_allowed <= 1'b0;
                    if (i_operation == OP_CLEAR) begin
                        r_cnt <= '0;
                        o_regions_in_use <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_op == OP_MAP) begin
                        if (r_bad) r_i <= r_cnt;
                        else if (in_tab) begin
                            if (cs < r_e && r_s < ce) r_bad <= 1'b1;
                            if (cs < r_s) r_pos <= r_i + 1'b1;
                            r_i <= r_i + 1'b1;
                        end
                    end else if (r_op == OP_LOOKUP) begin
                        if (in_tab) begin
                            if (contains && !r_found) begin
                                r_found <= 1'b1; r_k <= ix;
                            end
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        if (r_bad || !(r_s < r_e)) r_i <= r_cnt;
                        else if (in_tab) begin
                            if (contains) begin
                                r_k <= ix; r_found <= 1'b1; r_i <= r_cnt;
                            end else r_i <= r_i + 1'b1;
                        end
                    end
                    if (!in_tab) begin
                        o_regions_in_use <= 5'(r_cnt);
                        case (r_op)
                            OP_MAP: begin
                                if (r_bad) o_status <= ST_BAD;
                                else if (r_cnt >= CntW'(MaxRegions)) o_status <= ST_FULL;
                            end
                            OP_LOOKUP: if (r_found) begin
                                o_hit <= 1'b1;
                                o_region_index <= 4'(r_k);
                                o_found_start <= 39'({r_sp[r_k], {PageShift{1'b0}}});
                                o_found_end <= 40'({r_ep[r_k], {PageShift{1'b0}}});
                                o_found_permissions <= r_fl[r_k];
                            end
                            OP_CHECK: begin
                                if (r_bad) o_allowed <= 1'b0;
                                else if (!(r_s < r_e)) o_allowed <= 1'b1;
                                else if (!r_found) o_allowed <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (r_i == r_pos) begin
                        r_sp[r_pos[IdxW-1:0]] <= r_s[AddrBits-1:PageShift];
                        r_ep[r_pos[IdxW-1:0]] <= r_e[AddrBits:PageShift];
                        r_fl[r_pos[IdxW-1:0]] <= r_perm;
                        r_cnt <= r_cnt + 1'b1;
                        o_regions_in_use <= 5'(r_cnt + 1'b1);
                        o_region_index <= 4'(r_pos);
                        o_found_start <= 39'(r_s);
                        o_found_end <= 40'(r_e);
                        o_found_permissions <= r_perm;
                    end else begin
                        r_sp[ix] <= r_sp[ix - 1'b1];
                        r_ep[ix] <= r_ep[ix - 1'b1];
                        r_fl[ix] <= r_fl[ix - 1'b1];
                        r_i <= r_i - 1'b1;
                    end
                end
                S_CHK: begin
                    if (chk_fail) begin
                        o_allowed <= 1'b0;
                    end else begin
                        r_s <= {r_ep[r_k], {PageShift{1'b0}}};
                        r_i <= '0;
                        r_found <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
